// ===== rtl/gres_pkg.sv =====
package gres_pkg;

  localparam int MAX_RUNS_DEF  = 4;
  localparam int MAX_SHIFT_DEF = 2;
  localparam int ROW_COLS_DEF  = 32;
  localparam int SHIFT_HI      = 8;
  localparam int OUT_LIMIT     = 16;
  localparam int DIV_W         = 28;
  localparam int Q_W           = 16;
  localparam logic [11:0] LINE_WIDTH_RST = 12'd720;

  localparam logic [1:0] KIND_SPAN = 2'd0;
  localparam logic [1:0] KIND_PART = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_SCAN, ST_EDGE, ST_ML, ST_MR, ST_MW,
    ST_E0, ST_E1, ST_E2, ST_DONE
  } gres_state_t;

  // twice the boundary column: own column plus nearest matching edge
  function automatic logic [6:0] boundary2(input logic [31:0] edges,
                                           input logic [5:0] col,
                                           input int max_shift,
                                           input int row_cols);
    int c;
    logic [6:0] r;
    logic found;
    r = {col, 1'b0};
    found = 1'b0;
    for (int d = 0; d <= SHIFT_HI; d++) begin
      if (!found && d <= max_shift) begin
        c = int'(col) + d;
        if (c < row_cols) begin
          if (edges[31 - c]) begin
            r = 7'(2 * int'(col) + d);
            found = 1'b1;
          end
        end
        if (!found && d > 0) begin
          c = int'(col) - d;
          if (c >= 0) begin
            if (edges[31 - c]) begin
              r = 7'(2 * int'(col) - d);
              found = 1'b1;
            end
          end
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/gres_div.sv =====
module gres_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [gres_pkg::DIV_W-1:0] dividend,
  input  logic [12:0]               divisor,
  output logic                      done,
  output logic [gres_pkg::Q_W-1:0]  quo
);
  import gres_pkg::*;

  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [12:0]      rem_r, rem_nxt;
  logic [12:0]      dsr_r, dsr_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [13:0]      trial;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, dvd_r[DIV_W-1]};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = 5'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 13'(trial - {1'b0, dsr_r});
        dvd_nxt = {dvd_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[12:0];
        dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = dvd_r[Q_W-1:0];

endmodule

// ===== rtl/gres_interp.sv =====
module gres_interp (
  input  logic               clk,
  input  logic signed [17:0] base,
  input  logic signed [15:0] delta,
  input  logic [15:0]        q,
  output logic signed [17:0] res
);
  import gres_pkg::*;

  logic signed [32:0] prod;
  logic signed [32:0] rnd;
  logic signed [17:0] res_r, res_nxt;

  // base + floor((delta * q + 32768) / 65536)
  always_comb begin
    prod    = $signed({{17{delta[15]}}, delta}) * $signed({17'b0, q});
    rnd     = (prod + 33'sd32768) >>> 16;
    res_nxt = base + rnd[17:0];
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== rtl/glyph_row_edge_smoothed_spans.sv =====
// Glyph row renderer: one font row of one character in, drawing commands out.
// Input: pulse start with the in_ fields while busy is low; the item is taken
// at that edge and busy stays high until its commands are out.
// Output: each command shows on the out_ ports for one cycle with out_strobe;
// out_last marks the final one. An item with no command gives one beat of
// kind "nothing drawn". At most 16 commands per item.
// Config: cfg_we with cfg_line_width writes the line width; write only while
// idle. Reset sets it to 720 and clears the sequencer and the output strobe.
// Sequence: the row is scanned one column per cycle, plus entry and wrap-up;
// in smoothed mode the scan pauses while each closed run is worked. In
// smoothed mode a bit-serial divide for the band fraction comes first, and
// each smoothed run adds an edge search, two passes through the shared
// interpolation multiplier, and up to three emit steps. Each command is held
// back until the next one is found; the final one leaves as busy drops.
// The receiver cannot stall, so there is no backpressure path.
module glyph_row_edge_smoothed_spans #(
  parameter int MAX_RUNS  = gres_pkg::MAX_RUNS_DEF,
  parameter int MAX_SHIFT = gres_pkg::MAX_SHIFT_DEF,
  parameter int ROW_COLS  = gres_pkg::ROW_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic [31:0]        in_row_bits,
  input  logic [31:0]        in_above_bits,
  input  logic [31:0]        in_below_bits,
  input  logic signed [11:0] in_glyph_x,
  input  logic [4:0]         in_pixel_scale,
  input  logic [11:0]        in_row_in_band,
  input  logic [12:0]        in_band_height,
  input  logic               cfg_we,
  input  logic [11:0]        cfg_line_width,
  output logic               out_strobe,
  output logic [1:0]         out_kind,
  output logic signed [12:0] out_x_start,
  output logic signed [12:0] out_x_end,
  output logic [4:0]         out_coverage,
  output logic               out_last
);
  import gres_pkg::*;

  localparam int RUN_W = $clog2(MAX_RUNS + 1);
  localparam logic [31:0] ROW_MASK = ~(32'hFFFF_FFFF >> ROW_COLS);

  gres_state_t state_r, state_nxt;

  logic [11:0]        lw_r;
  logic               mode_r, mode_nxt;
  logic [31:0]        sh_r, sh_nxt;
  logic [31:0]        bits_r, bits_nxt, above_r, above_nxt, below_r, below_nxt;
  logic signed [11:0] gx_r, gx_nxt;
  logic [4:0]         sx_r, sx_nxt;
  logic [5:0]         col_r, col_nxt, l_r, l_nxt, e_r, e_nxt;
  logic               in_run_r, in_run_nxt;
  logic [RUN_W-1:0]   runs_r, runs_nxt;
  logic signed [17:0] lt_r, lt_nxt, rt_r, rt_nxt, xl_r, xl_nxt, xr_r, xr_nxt;
  logic signed [15:0] dl_r, dl_nxt, dr_r, dr_nxt;
  logic signed [13:0] a_r, a_nxt, b_r, b_nxt;
  logic [3:0]         fr_r, fr_nxt;
  logic [4:0]         cnt_r, cnt_nxt;

  logic               pend_vld_r, pend_vld_nxt;
  logic [1:0]         pend_kind_r, pend_kind_nxt;
  logic signed [12:0] pend_xs_r, pend_xs_nxt, pend_xe_r, pend_xe_nxt;
  logic [4:0]         pend_cov_r, pend_cov_nxt;

  logic               out_strobe_r, out_strobe_nxt, out_last_r, out_last_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic signed [12:0] out_xs_r, out_xs_nxt, out_xe_r, out_xe_nxt;
  logic [4:0]         out_cov_r, out_cov_nxt;

  logic               accept;
  logic [12:0]        bh_eff;
  logic [11:0]        dy_sat;
  logic [DIV_W-1:0]   dividend;
  logic               div_done;
  logic [Q_W-1:0]     q;

  logic               scan_end, ink, scan_close, aflat, bflat, run_last;
  logic [31:0]        al_e, ar_e, bl_e, br_e;
  logic [6:0]         b2_lt, b2_lb, b2_rt, b2_rb;
  logic signed [13:0] a_w, b_w;
  logic [3:0]         fl_w;
  logic               run_empty, same_px;

  logic signed [17:0] ip_base, ip_res;
  logic signed [15:0] ip_delta;

  logic               emit_en;
  logic [1:0]         emit_kind;
  logic signed [12:0] emit_xs, emit_xe;
  logic [4:0]         emit_cov;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    bh_eff   = (in_band_height == 13'd0) ? 13'd1 : in_band_height;
    dy_sat   = ({1'b0, in_row_in_band} > (bh_eff - 13'd1)) ? 12'(bh_eff - 13'd1)
                                                            : in_row_in_band;
    dividend = {dy_sat, 16'b0} + DIV_W'(bh_eff >> 1);
  end

  gres_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && in_mode),
    .dividend (dividend),
    .divisor  (bh_eff),
    .done     (div_done),
    .quo      (q)
  );

  assign ip_base  = (state_r == ST_MR) ? rt_r : lt_r;
  assign ip_delta = (state_r == ST_MR) ? dr_r : dl_r;

  gres_interp u_interp (
    .clk   (clk),
    .base  (ip_base),
    .delta (ip_delta),
    .q     (q),
    .res   (ip_res)
  );

  // shared status terms
  always_comb begin
    scan_end   = (col_r == 6'(ROW_COLS));
    ink        = sh_r[31];
    scan_close = scan_end ? in_run_r : (in_run_r && !ink);
    aflat      = (above_r == '0) || (above_r == bits_r);
    bflat      = (below_r == '0) || (below_r == bits_r);
    al_e       = above_r & ~(above_r >> 1);
    ar_e       = (above_r >> 1) & ~above_r;
    bl_e       = below_r & ~(below_r >> 1);
    br_e       = (below_r >> 1) & ~below_r;
    b2_lt = aflat ? {l_r, 1'b0} : boundary2(al_e, l_r, MAX_SHIFT, ROW_COLS);
    b2_rt = aflat ? {e_r, 1'b0} : boundary2(ar_e, e_r, MAX_SHIFT, ROW_COLS);
    b2_lb = bflat ? {l_r, 1'b0} : boundary2(bl_e, l_r, MAX_SHIFT, ROW_COLS);
    b2_rb = bflat ? {e_r, 1'b0} : boundary2(br_e, e_r, MAX_SHIFT, ROW_COLS);
    a_w       = 14'(xl_r >>> 4);
    b_w       = 14'(xr_r >>> 4);
    fl_w      = xl_r[3:0];
    run_empty = (xr_r <= xl_r);
    same_px   = (a_w == b_w);
    run_last  = (runs_r == RUN_W'(MAX_RUNS));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = in_mode ? ST_DIV : ST_SCAN;
      ST_DIV:  if (div_done) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_close && mode_r) state_nxt = ST_EDGE;
        else if (scan_end && !in_run_r) state_nxt = ST_DONE;
      end
      ST_EDGE: state_nxt = ST_ML;
      ST_ML:   state_nxt = ST_MR;
      ST_MR:   state_nxt = ST_MW;
      ST_MW:   state_nxt = ST_E0;
      ST_E0: begin
        if (run_empty || same_px) state_nxt = run_last ? ST_DONE : ST_SCAN;
        else state_nxt = ST_E1;
      end
      ST_E1:   state_nxt = ST_E2;
      ST_E2:   state_nxt = run_last ? ST_DONE : ST_SCAN;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and command emission
  always_comb begin
    mode_nxt = mode_r;   sh_nxt = sh_r;     bits_nxt = bits_r;
    above_nxt = above_r; below_nxt = below_r;
    gx_nxt = gx_r;       sx_nxt = sx_r;     col_nxt = col_r;
    l_nxt = l_r;         e_nxt = e_r;       in_run_nxt = in_run_r;
    runs_nxt = runs_r;   lt_nxt = lt_r;     rt_nxt = rt_r;
    dl_nxt = dl_r;       dr_nxt = dr_r;     xl_nxt = xl_r;  xr_nxt = xr_r;
    a_nxt = a_r;         b_nxt = b_r;       fr_nxt = fr_r;  cnt_nxt = cnt_r;
    pend_vld_nxt = pend_vld_r; pend_kind_nxt = pend_kind_r;
    pend_xs_nxt = pend_xs_r;   pend_xe_nxt = pend_xe_r; pend_cov_nxt = pend_cov_r;
    out_strobe_nxt = 1'b0; out_last_nxt = 1'b0; out_kind_nxt = out_kind_r;
    out_xs_nxt = out_xs_r; out_xe_nxt = out_xe_r; out_cov_nxt = out_cov_r;
    emit_en = 1'b0; emit_kind = KIND_SPAN;
    emit_xs = '0;   emit_xe = '0;  emit_cov = 5'd16;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt  = in_mode;
          bits_nxt  = in_row_bits & ROW_MASK;
          sh_nxt    = in_row_bits & ROW_MASK;
          above_nxt = in_above_bits & ROW_MASK;
          below_nxt = in_below_bits & ROW_MASK;
          gx_nxt    = in_glyph_x;
          sx_nxt    = (in_pixel_scale == 5'd0) ? 5'd1 : in_pixel_scale;
          col_nxt   = '0;
          in_run_nxt = 1'b0;
          runs_nxt  = '0;
          cnt_nxt   = '0;
          pend_vld_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (!scan_end) begin
          sh_nxt  = {sh_r[30:0], 1'b0};
          col_nxt = col_r + 6'd1;
          if (ink && !in_run_r) begin
            l_nxt      = col_r;
            in_run_nxt = 1'b1;
          end
        end
        if (scan_close) begin
          in_run_nxt = 1'b0;
          e_nxt      = col_r;
          if (mode_r) begin
            runs_nxt = runs_r + RUN_W'(1);
          end else begin
            emit_en = 1'b1;
            emit_xs = 13'($signed({gx_r[11], gx_r}) +
                          $signed({2'b0, 11'(l_r) * 11'(sx_r)}));
            emit_xe = 13'($signed({gx_r[11], gx_r}) +
                          $signed({2'b0, 11'(col_r) * 11'(sx_r)}));
          end
        end
      end
      ST_EDGE: begin
        lt_nxt = $signed({{2{gx_r[11]}}, gx_r, 4'b0}) +
                 $signed({4'b0, 11'(b2_lt) * 11'(sx_r), 3'b0});
        rt_nxt = $signed({{2{gx_r[11]}}, gx_r, 4'b0}) +
                 $signed({4'b0, 11'(b2_rt) * 11'(sx_r), 3'b0});
        dl_nxt = ($signed(16'(signed'({1'b0, b2_lb}) - signed'({1'b0, b2_lt}))) *
                  $signed({11'b0, sx_r})) <<< 3;
        dr_nxt = ($signed(16'(signed'({1'b0, b2_rb}) - signed'({1'b0, b2_rt}))) *
                  $signed({11'b0, sx_r})) <<< 3;
      end
      ST_MR: xl_nxt = ip_res;
      ST_MW: xr_nxt = ip_res;
      ST_E0: begin
        b_nxt  = b_w;
        fr_nxt = xr_r[3:0];
        a_nxt  = a_w;
        if (!run_empty) begin
          if (same_px) begin
            emit_en   = 1'b1;
            emit_kind = KIND_PART;
            emit_xs   = 13'(a_w);
            emit_cov  = 5'(xr_r - xl_r);
          end else if (fl_w != 4'd0) begin
            emit_en   = 1'b1;
            emit_kind = KIND_PART;
            emit_xs   = 13'(a_w);
            emit_cov  = 5'd16 - {1'b0, fl_w};
            a_nxt     = a_w + 14'sd1;
          end
        end
      end
      ST_E1: begin
        if (a_r < b_r) begin
          emit_en = 1'b1;
          emit_xs = 13'(a_r);
          emit_xe = 13'(b_r);
        end
      end
      ST_E2: begin
        if (fr_r != 4'd0) begin
          emit_en   = 1'b1;
          emit_kind = KIND_PART;
          emit_xs   = 13'(b_r);
          emit_cov  = {1'b0, fr_r};
        end
      end
      ST_DONE: begin
        out_strobe_nxt = 1'b1;
        out_last_nxt   = 1'b1;
        if (pend_vld_r) begin
          out_kind_nxt = pend_kind_r; out_xs_nxt = pend_xs_r;
          out_xe_nxt   = pend_xe_r;   out_cov_nxt = pend_cov_r;
        end else begin
          out_kind_nxt = KIND_NONE; out_xs_nxt = '0;
          out_xe_nxt   = '0;        out_cov_nxt = '0;
        end
        pend_vld_nxt = 1'b0;
      end
      default: ;
    endcase

    // partials off the line are dropped
    if (emit_en && emit_kind == KIND_PART) begin
      emit_xe = emit_xs;
      if (emit_xs < 13'sd0 || emit_xs >= $signed({1'b0, lw_r})) emit_en = 1'b0;
    end

    // one command held back so the final beat can carry last
    if (emit_en && cnt_r < 5'(OUT_LIMIT)) begin
      if (pend_vld_r) begin
        out_strobe_nxt = 1'b1;
        out_kind_nxt = pend_kind_r; out_xs_nxt = pend_xs_r;
        out_xe_nxt   = pend_xe_r;   out_cov_nxt = pend_cov_r;
      end
      pend_vld_nxt  = 1'b1;
      pend_kind_nxt = emit_kind;
      pend_xs_nxt   = emit_xs;
      pend_xe_nxt   = emit_xe;
      pend_cov_nxt  = emit_cov;
      cnt_nxt       = cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;   sh_r <= sh_nxt;       bits_r <= bits_nxt;
    above_r <= above_nxt; below_r <= below_nxt;
    gx_r <= gx_nxt;       sx_r <= sx_nxt;       col_r <= col_nxt;
    l_r <= l_nxt;         e_r <= e_nxt;         in_run_r <= in_run_nxt;
    runs_r <= runs_nxt;   lt_r <= lt_nxt;       rt_r <= rt_nxt;
    dl_r <= dl_nxt;       dr_r <= dr_nxt;       xl_r <= xl_nxt;  xr_r <= xr_nxt;
    a_r <= a_nxt;         b_r <= b_nxt;         fr_r <= fr_nxt;  cnt_r <= cnt_nxt;
    pend_kind_r <= pend_kind_nxt; pend_xs_r <= pend_xs_nxt;
    pend_xe_r <= pend_xe_nxt;     pend_cov_r <= pend_cov_nxt;
    out_kind_r <= out_kind_nxt;   out_xs_r <= out_xs_nxt;
    out_xe_r <= out_xe_nxt;       out_cov_r <= out_cov_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pend_vld_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      lw_r         <= LINE_WIDTH_RST;
    end else begin
      state_r      <= state_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) lw_r <= cfg_line_width;
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_kind     = out_kind_r;
  assign out_x_start  = out_xs_r;
  assign out_x_end    = out_xe_r;
  assign out_coverage = out_cov_r;
  assign out_last     = out_last_r;

endmodule

// ===== rtl/gres_checker.sv =====
module gres_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic [1:0] out_kind,
  input logic [4:0] out_coverage,
  input logic       out_last
);
  import gres_pkg::*;

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("item taken but busy not set");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy) else $error("final beat while still busy");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_NONE |-> out_last)
    else $error("empty marker not final");

  a_span_cov: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_SPAN |-> out_coverage == 5'd16)
    else $error("span without full coverage");

  a_no_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy) else $error("stray beat while idle");

endmodule

bind glyph_row_edge_smoothed_spans gres_checker u_gres_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_strobe   (out_strobe),
  .out_kind     (out_kind),
  .out_coverage (out_coverage),
  .out_last     (out_last)
);
